// ===== sv/mcds_pkg.sv =====
// Types, constants and helpers shared by the display scanner files.
package mcds_pkg;

  localparam int unsigned TPS_W = 16;
  localparam logic [TPS_W-1:0] TPS_RESET = 16'd20000;
  localparam logic [4:0] PHASE_LAST = 5'd17;
  localparam logic [4:0] PHASE_OFF = 5'd15;
  localparam logic [5:0] SECS_PER_MIN = 6'd60;
  localparam logic [2:0] DOT_BIT = 3'd7;
  localparam logic [1:0] COLON_DIGIT = 2'd1;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef logic [7:0] seg_t;

  typedef struct packed {
    logic       resync;
    logic       led;
    logic [3:0] digit;
    logic       latch;
    logic       sdata;
    logic       sclk;
  } pins_t;

  localparam seg_t SEG_TABLE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // segment bit sent at even phases 0,2,..,14: F,G,A,H,E,B,C,D
  localparam logic [2:0] SEND_ORDER [8] = '{
    3'd5, 3'd6, 3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd3
  };

  // quotient by ten for values below 64: multiply by 205, shift by 11
  function automatic logic [3:0] div10(input logic [5:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'd205;
    return {1'b0, p[13:11]};
  endfunction

  function automatic logic [3:0] mod10(input logic [5:0] v);
    logic [5:0] q10;
    q10 = 6'(div10(v)) * 6'd10;
    return 4'(v - q10);
  endfunction

  function automatic seg_t seg_of(input logic [3:0] d);
    seg_t s;
    s = '0;
    if (d < 4'd10) begin
      s = SEG_TABLE[d];
    end
    return s;
  endfunction

endpackage

// ===== sv/mcds_ifs.sv =====
// Channel interfaces: time/tick input, pin-level result, config write.
interface mcds_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;

  modport source (output valid, cmd, hour, minute, second, input ready);
  modport sink (input valid, cmd, hour, minute, second, output ready);
endinterface

interface mcds_out_if;
  logic       valid;
  logic       ready;
  logic       shift_clock;
  logic       shift_data;
  logic       latch_clock;
  logic [3:0] digit_enable;
  logic       status_led;
  logic       resync_request;

  modport source (output valid, shift_clock, shift_data, latch_clock, digit_enable,
                  status_led, resync_request, input ready);
  modport sink (input valid, shift_clock, shift_data, latch_clock, digit_enable,
                status_led, resync_request, output ready);
endinterface

interface mcds_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/multiplexed_clock_display_scanner.sv =====
// A beat accepted at a clock edge shows its pin levels on out_ch from that edge on.
// Throughput: one beat per cycle while out_ch.ready stays high; in_ch.ready is high while the result slot is empty
// or being taken in the same cycle.
// Reset (rst_n low, synchronous): patterns, counters and pins clear, colon on,
// resync request high, ticks_per_second back to 20000, no result pending.
module multiplexed_clock_display_scanner (
  input  logic           clk,
  input  logic           rst_n,
  mcds_in_if.sink        in_ch,
  mcds_out_if.source     out_ch,
  mcds_cfg_if.sink       cfg_ch
);
  import mcds_pkg::*;

  seg_t             seg_r   [4];
  seg_t             seg_nxt [4];
  logic [4:0]       phase_r, phase_nxt;
  logic [1:0]       digit_r, digit_nxt;
  logic [TPS_W-1:0] tick_r, tick_nxt;
  logic [5:0]       secs_r, secs_nxt;
  logic [5:0]       limit_r, limit_nxt;
  logic             colon_r, colon_nxt;
  pins_t            pins_r, pins_nxt;
  logic [TPS_W-1:0] tps_r;
  logic             out_valid_r;

  logic             accept;
  logic [2:0]       segbit;
  logic [TPS_W:0]   tick_inc;
  logic [5:0]       secs_inc;
  seg_t             cur_seg;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      seg_nxt[k] = seg_r[k];
    end
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    tick_nxt  = tick_r;
    secs_nxt  = secs_r;
    limit_nxt = limit_r;
    colon_nxt = colon_r;
    pins_nxt  = pins_r;
    segbit    = SEND_ORDER[phase_r[3:1]];
    tick_inc  = {1'b0, tick_r} + 1'b1;
    secs_inc  = secs_r + 6'd1;
    cur_seg   = seg_r[digit_r];

    if (in_ch.cmd == CMD_LOAD) begin
      seg_nxt[0] = seg_of(div10({1'b0, in_ch.hour}));
      seg_nxt[1] = seg_of(mod10({1'b0, in_ch.hour}));
      seg_nxt[2] = seg_of(div10(in_ch.minute));
      seg_nxt[3] = seg_of(mod10(in_ch.minute));
      limit_nxt  = (in_ch.second >= SECS_PER_MIN) ? 6'd0 : 6'(SECS_PER_MIN - in_ch.second);
      pins_nxt.resync = 1'b0;
    end else begin
      if (phase_r <= PHASE_OFF) begin
        pins_nxt.latch = 1'b0;
        if (!phase_r[0]) begin
          pins_nxt.sclk = 1'b0;
          if (segbit == DOT_BIT && digit_r == COLON_DIGIT) begin
            seg_nxt[1][DOT_BIT] = colon_r;
            cur_seg[DOT_BIT]    = colon_r;
          end
          pins_nxt.sdata = cur_seg[segbit];
        end else begin
          pins_nxt.sclk = 1'b1;
          if (phase_r == PHASE_OFF) begin
            pins_nxt.digit[digit_r - 2'd1] = 1'b0;
          end
        end
      end else begin
        pins_nxt.sclk           = 1'b0;
        pins_nxt.latch          = 1'b1;
        pins_nxt.digit[digit_r] = 1'b1;
        if (phase_r == PHASE_LAST) begin
          digit_nxt = digit_r + 2'd1;
        end
      end

      phase_nxt = (phase_r >= PHASE_LAST) ? 5'd0 : phase_r + 5'd1;

      if (tick_inc > {1'b0, tps_r}) begin
        colon_nxt    = !colon_r;
        pins_nxt.led = !pins_r.led;
        tick_nxt     = '0;
        if (secs_inc > limit_r) begin
          pins_nxt.resync = 1'b1;
          secs_nxt        = '0;
        end else begin
          secs_nxt = secs_inc;
        end
      end else begin
        tick_nxt = tick_inc[TPS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        seg_r[k] <= '0;
      end
      phase_r     <= '0;
      digit_r     <= '0;
      tick_r      <= '0;
      secs_r      <= '0;
      limit_r     <= '0;
      colon_r     <= 1'b1;
      pins_r      <= '{resync: 1'b1, default: '0};
      tps_r       <= TPS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        tps_r <= cfg_ch.data;
      end
      if (accept) begin
        seg_r       <= seg_nxt;
        phase_r     <= phase_nxt;
        digit_r     <= digit_nxt;
        tick_r      <= tick_nxt;
        secs_r      <= secs_nxt;
        limit_r     <= limit_nxt;
        colon_r     <= colon_nxt;
        pins_r      <= pins_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pin state only moves on accept, which needs the slot free or being taken, so it is the result register
  assign out_ch.valid          = out_valid_r;
  assign out_ch.shift_clock    = pins_r.sclk;
  assign out_ch.shift_data     = pins_r.sdata;
  assign out_ch.latch_clock    = pins_r.latch;
  assign out_ch.digit_enable   = pins_r.digit;
  assign out_ch.status_led     = pins_r.led;
  assign out_ch.resync_request = pins_r.resync;

endmodule

// ===== sv/mcds_checker.sv =====
// Port-level checker for the display scanner, bound to the top level.
module mcds_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       shift_clock,
  input logic       latch_clock,
  input logic [3:0] digit_enable
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat gave no result");

  a_clk_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(shift_clock && latch_clock))
    else $error("shift and latch clocks high together");

  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(digit_enable))
    else $error("more than one digit enabled");

  a_latch_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && latch_clock |-> digit_enable != 4'd0)
    else $error("latch raised with no digit enabled");

endmodule

bind multiplexed_clock_display_scanner mcds_checker u_mcds_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .shift_clock  (out_ch.shift_clock),
  .latch_clock  (out_ch.latch_clock),
  .digit_enable (out_ch.digit_enable)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the display scanner: time loads and scan ticks checked against a pin predictor.
module tb_top;
  import mcds_pkg::*;

  typedef struct packed {
    logic       sclk;
    logic       sdata;
    logic       latch;
    logic [3:0] digit;
    logic       led;
    logic       resync;
  } pin_set_t;

  localparam logic [7:0] GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  // F,G,A,H,E,B,C,D
  localparam logic [2:0] BIT_ORDER [8] = '{
    3'd5, 3'd6, 3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd3
  };

  class pin_scoreboard;
    logic [7:0]  pattern [4];
    logic [4:0]  phase;
    logic [1:0]  digit;
    logic [15:0] ticks;
    logic [5:0]  secs;
    logic [5:0]  limit;
    logic        colon;
    pin_set_t    pins;
    logic [15:0] tps;
    pin_set_t    levels_due [$];
    int unsigned errors;

    function new();
      for (int k = 0; k < 4; k++) pattern[k] = '0;
      phase = '0;
      digit = '0;
      ticks = '0;
      secs = '0;
      limit = '0;
      colon = 1'b1;
      pins = '0;
      pins.resync = 1'b1;
      tps = 16'd20000;
      errors = 0;
    endfunction

    function void set_tps(logic [15:0] v);
      tps = v;
    endfunction

    function void scan_tick();
      logic [2:0] b;
      logic [1:0] d;
      logic [1:0] prev;
      d = digit;
      prev = d - 2'd1;
      if (phase <= 5'd15) begin
        pins.latch = 1'b0;
        if (!phase[0]) begin
          b = BIT_ORDER[phase[3:1]];
          pins.sclk = 1'b0;
          if (b == 3'd7 && d == 2'd1) pattern[1][7] = colon;
          pins.sdata = pattern[d][b];
        end else begin
          pins.sclk = 1'b1;
          if (phase == 5'd15) pins.digit[prev] = 1'b0;
        end
      end else begin
        pins.sclk = 1'b0;
        pins.latch = 1'b1;
        pins.digit[d] = 1'b1;
        if (phase == 5'd17) digit = d + 2'd1;
      end
      phase = (phase >= 5'd17) ? 5'd0 : phase + 5'd1;
      if (17'(ticks) + 17'd1 > 17'(tps)) begin
        colon = ~colon;
        pins.led = ~pins.led;
        secs = secs + 6'd1;
        if (secs > limit) begin
          pins.resync = 1'b1;
          secs = '0;
        end
        ticks = '0;
      end else begin
        ticks = ticks + 16'd1;
      end
    endfunction

    function void load_time(logic [4:0] hour, logic [5:0] minute, logic [5:0] second);
      pattern[0] = GLYPH[(hour / 10) % 10];
      pattern[1] = GLYPH[hour % 10];
      pattern[2] = GLYPH[(minute / 10) % 10];
      pattern[3] = GLYPH[minute % 10];
      limit = (second >= 6'd60) ? 6'd0 : 6'd60 - second;
      pins.resync = 1'b0;
    endfunction

    function void note_item(cmd_t cmd, logic [4:0] hour, logic [5:0] minute,
                            logic [5:0] second);
      if (cmd == CMD_LOAD) load_time(hour, minute, second);
      else scan_tick();
      levels_due.push_back(pins);
    endfunction

    function void report(string what, pin_set_t want, pin_set_t got);
      errors++;
      if (errors <= 10) begin
        $write("%s: want sclk=%0b sdata=%0b latch=%0b digit=%h led=%0b resync=%0b, ",
               what, want.sclk, want.sdata, want.latch, want.digit, want.led, want.resync);
        $display("got sclk=%0b sdata=%0b latch=%0b digit=%h led=%0b resync=%0b",
                 got.sclk, got.sdata, got.latch, got.digit, got.led, got.resync);
      end
    endfunction

    function void check_pins(pin_set_t got);
      pin_set_t want;
      if (levels_due.size() == 0) begin
        report("unexpected beat", '0, got);
        return;
      end
      want = levels_due.pop_front();
      if (got.sclk !== want.sclk || got.sdata !== want.sdata || got.latch !== want.latch ||
          got.digit !== want.digit || got.led !== want.led || got.resync !== want.resync)
        report("pin mismatch", want, got);
    endfunction

    function int pending();
      return levels_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  bit   in_took = 1'b0;
  bit   cfg_took = 1'b0;
  pin_scoreboard sb = new();

  mcds_in_if  in_if();
  mcds_out_if out_if();
  mcds_cfg_if cfg_if();

  multiplexed_clock_display_scanner u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    pin_set_t got;
    in_took = rst_n && in_if.valid && in_if.ready;
    cfg_took = rst_n && cfg_if.valid && cfg_if.ready;
    if (cfg_took) sb.set_tps(cfg_if.data);
    if (in_took) sb.note_item(cmd_t'(in_if.cmd), in_if.hour, in_if.minute, in_if.second);
    if (rst_n && out_if.valid && out_if.ready) begin
      got.sclk = out_if.shift_clock;
      got.sdata = out_if.shift_data;
      got.latch = out_if.latch_clock;
      got.digit = out_if.digit_enable;
      got.led = out_if.status_led;
      got.resync = out_if.resync_request;
      sb.check_pins(got);
    end
  end

  task automatic send_item(cmd_t cmd, logic [4:0] hour, logic [5:0] minute,
                           logic [5:0] second);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= cmd;
    in_if.hour <= hour;
    in_if.minute <= minute;
    in_if.second <= second;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic tick_beats(int n);
    repeat (n) send_item(CMD_TICK, 5'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic send_random();
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
    h = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
    m = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    s = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
    if ($urandom_range(0, 11) == 0) send_item(CMD_LOAD, h, m, s);
    else send_item(CMD_TICK, h, m, s);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_tps(logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(negedge clk); while (!cfg_took);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [15:0] tps, int mode, int n);
    drain();
    write_tps(tps);
    case (mode)
      0: begin in_idle_pct = 0; out_stall_pct = 0; end
      1: begin in_idle_pct = 69; out_stall_pct = 0; end
      2: begin in_idle_pct = 0; out_stall_pct = 69; end
      default: begin in_idle_pct = 11; out_stall_pct = 11; end
    endcase
    repeat (n) send_random();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TICK;
    in_if.hour = '0;
    in_if.minute = '0;
    in_if.second = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // blank digits, resync high out of reset, default rate
    tick_beats(2);
    drain();
    // fires every tick
    write_tps(16'd0);
    send_item(CMD_LOAD, 5'd23, 6'd59, 6'd59);
    send_item(CMD_LOAD, 5'd0, 6'd0, 6'd0);
    send_item(CMD_LOAD, 5'd31, 6'd63, 6'd63);
    tick_beats(3);
    send_item(CMD_LOAD, 5'd19, 6'd38, 6'd60);
    tick_beats(16);

    run_phase(16'd1, 0, 160);
    run_phase(16'd0, 1, 160);
    run_phase(16'd65535, 2, 160);
    run_phase(16'd2, 3, 160);
    run_phase(16'($urandom_range(3, 25)), 0, 160);
    run_phase(16'd1, 1, 160);
    run_phase(16'($urandom_range(0, 7)), 2, 160);
    run_phase(16'd5, 3, 160);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
